### sv/psts_pkg.sv
`default_nettype none

package psts_pkg;

  localparam int WAKE_W     = 16;
  localparam int SEC_W      = 32;
  localparam int PERIOD_W   = 32;
  localparam int FRAC_W     = 17;
  localparam int SLOT_W     = 3;
  localparam int DATA_W     = 40;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // slot entry: {has_action, period, due_time}
  localparam int ENTRY_W = 1 + PERIOD_W + SEC_W;

  localparam logic [CFG_ADDR_W-1:0] REG_WAKE_INTERVAL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PERIOD    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PERIOD    = 2'd2;

  localparam logic [WAKE_W-1:0]   WAKE_RST = 16'd4096;
  localparam logic [PERIOD_W-1:0] MIN_RST  = 32'd1;
  localparam logic [PERIOD_W-1:0] MAX_RST  = 32'd86400;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_WR,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### sv/psts_ram.sv
`default_nettype none

module psts_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/periodic_second_timer_scheduler.sv
// Tick without second rollover: accept, then the status request from the done state.
// Start: clamp at accept, then slot write, then the status request from the done state.
// Tick with rollover: reciprocal-multiply quotient, then for each slot a slot RAM
// read, then compare and write back, then the status request.
// Ready only when idle, so requests do not overlap; a waiting output stalls it.
// Reset (sync, high): counters, running flags, config to defaults; slot RAM not cleared.
`default_nettype none

module periodic_second_timer_scheduler #(
  parameter int SLOTS            = 8,
  parameter int TICKS_PER_SECOND = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // slot[2:0], period_sec[34:3], has_action[35]
  input  wire logic [psts_pkg::DATA_W-1:0]        s_axis_tdata,
  // mode
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // fired_slot[2:0], now_seconds[34:3]
  output logic      [psts_pkg::DATA_W-1:0]        m_axis_tdata,
  // fired
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [psts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [psts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W  = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int FW     = psts_pkg::FRAC_W;
  localparam int SW     = psts_pkg::SEC_W;
  localparam int PW     = psts_pkg::PERIOD_W;
  localparam int EW     = psts_pkg::ENTRY_W;
  localparam logic [FW:0]      TPS      = (FW + 1)'(TICKS_PER_SECOND);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  // quotient by reciprocal multiply, exact for every FW-bit dividend
  localparam int RSH = FW + $clog2(TICKS_PER_SECOND);
  localparam int MW  = FW + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RSH) + 64'(TICKS_PER_SECOND - 1)) / 64'(TICKS_PER_SECOND);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  psts_pkg::state_t state, state_next;

  logic [psts_pkg::WAKE_W-1:0] wake_interval;
  logic [PW-1:0]               min_period;
  logic [PW-1:0]               max_period;
  logic [SW-1:0]               seconds;
  logic [FW-1:0]               fraction;
  logic [SLOTS-1:0]            running;
  logic [IDX_W-1:0]            idx;
  logic [FW-1:0]               dvd;

  logic [psts_pkg::SLOT_W-1:0] slot_r;
  logic                        act_r;
  logic [PW-1:0]               pstart;

  logic                        out_valid;
  logic                        out_fired;
  logic [psts_pkg::SLOT_W-1:0] out_slot;
  logic [SW-1:0]               out_now;
  logic                        out_lst;

  logic                        in_acc;
  logic                        out_free;
  logic [psts_pkg::SLOT_W-1:0] in_slot;
  logic [PW-1:0]               in_period;
  logic                        in_act;
  logic [PW-1:0]               p_capmax;
  logic [PW-1:0]               p_clamp;
  logic [FW-1:0]               frac_sum;
  logic                        frac_ge;
  logic [FW+MW-1:0]            prod;
  logic [FW-1:0]               quotient;

  logic                        ram_we;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_waddr;
  logic [EW-1:0]               ram_wdata;
  logic [EW-1:0]               ram_rdata;
  logic                        rd_act;
  logic [PW-1:0]               rd_period;
  logic [SW-1:0]               rd_due;
  logic                        hit;
  logic                        slot_ok;
  logic [PW-1:0]               cap_src;
  logic [PW-1:0]               cap_val;
  logic [SW-1:0]               due_new;

  logic                        load;
  logic                        load_fired;
  logic                        load_last;
  logic                        chk_go;

  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;
  assign in_slot   = s_axis_tdata[2:0];
  assign in_period = s_axis_tdata[34:3];
  assign in_act    = s_axis_tdata[35];

  assign p_capmax  = (in_period > max_period) ? max_period : in_period;
  assign p_clamp   = (p_capmax < min_period) ? min_period : p_capmax;

  assign frac_sum  = fraction + FW'(wake_interval);
  assign frac_ge   = {1'b0, frac_sum} >= TPS;

  assign prod      = {{MW{1'b0}}, dvd} * {{FW{1'b0}}, RECIP};
  assign quotient  = FW'(prod >> RSH);

  assign {rd_act, rd_period, rd_due} = ram_rdata;
  assign hit     = running[idx] && (rd_due <= seconds);
  assign slot_ok = {29'd0, slot_r} < 32'(SLOTS);

  assign cap_src = (state == psts_pkg::ST_START_WR) ? pstart : rd_period;
  assign cap_val = (cap_src > max_period) ? max_period : cap_src;
  assign due_new = seconds + cap_val;

  assign ram_waddr = (state == psts_pkg::ST_START_WR) ? IDX_W'(slot_r) : idx;
  assign ram_wdata = (state == psts_pkg::ST_START_WR) ? {act_r, pstart, due_new}
                                                      : {rd_act, rd_period, due_new};

  assign s_axis_tready = (state == psts_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    load_fired = 1'b0;
    load_last  = 1'b1;
    chk_go     = 1'b0;
    case (state)
      psts_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == psts_pkg::MODE_START) begin
            state_next = psts_pkg::ST_START_WR;
          end else if (frac_ge) begin
            state_next = psts_pkg::ST_DIV;
          end else begin
            state_next = psts_pkg::ST_DONE;
          end
        end
      end
      psts_pkg::ST_START_WR: begin
        ram_we     = slot_ok;
        state_next = psts_pkg::ST_DONE;
      end
      psts_pkg::ST_DIV: begin
        state_next = psts_pkg::ST_SCAN_RD;
      end
      psts_pkg::ST_SCAN_RD: begin
        ram_re     = 1'b1;
        state_next = psts_pkg::ST_SCAN_CHK;
      end
      psts_pkg::ST_SCAN_CHK: begin
        if (!(hit && rd_act) || out_free) begin
          chk_go     = 1'b1;
          ram_we     = hit;
          load       = hit && rd_act;
          load_fired = 1'b1;
          load_last  = 1'b0;
          state_next = (idx == IDX_LAST) ? psts_pkg::ST_DONE : psts_pkg::ST_SCAN_RD;
        end
      end
      psts_pkg::ST_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = psts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_interval <= psts_pkg::WAKE_RST;
      min_period    <= psts_pkg::MIN_RST;
      max_period    <= psts_pkg::MAX_RST;
      seconds       <= '0;
      fraction      <= '0;
      running       <= '0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          psts_pkg::REG_WAKE_INTERVAL: wake_interval <= cfg_wdata[psts_pkg::WAKE_W-1:0];
          psts_pkg::REG_MIN_PERIOD:    min_period    <= cfg_wdata;
          psts_pkg::REG_MAX_PERIOD:    max_period    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc && s_axis_tuser == psts_pkg::MODE_TICK) begin
        fraction <= frac_ge ? '0 : frac_sum;
      end
      if (state == psts_pkg::ST_DIV) begin
        seconds <= seconds + SW'(quotient);
        idx     <= '0;
      end
      if (state == psts_pkg::ST_START_WR && slot_ok) begin
        running[IDX_W'(slot_r)] <= 1'b1;
      end
      if (chk_go && idx != IDX_LAST) begin
        idx <= idx + IDX_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= in_slot;
      act_r  <= in_act;
      pstart <= p_clamp;
      dvd    <= frac_sum;
    end
    if (load) begin
      out_fired <= load_fired;
      out_slot  <= load_fired ? psts_pkg::SLOT_W'(idx) : '0;
      out_now   <= seconds;
      out_lst   <= load_last;
    end
  end

  psts_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_fired;
  assign m_axis_tlast  = out_lst;
  assign m_axis_tdata  = {5'd0, out_now, out_slot};

  a_frac_below_second: assert property (@(posedge clk) disable iff (rst)
    state == psts_pkg::ST_IDLE |-> {1'b0, fraction} < TPS)
    else $error("fraction not below one second while idle");

  a_start_writes: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser == psts_pkg::MODE_START |=> state == psts_pkg::ST_START_WR)
    else $error("start request did not go to slot write");

  a_fire_is_due: assert property (@(posedge clk) disable iff (rst)
    state == psts_pkg::ST_SCAN_CHK && load |-> running[idx] && rd_due <= seconds && rd_act)
    else $error("fire request for a slot that is not due");

  a_div_to_scan: assert property (@(posedge clk) disable iff (rst)
    state == psts_pkg::ST_DIV |=> state == psts_pkg::ST_SCAN_RD && idx == '0)
    else $error("scan did not start at slot zero after the quotient");

endmodule

`default_nettype wire

### tb/periodic_second_timer_scheduler_tb.sv
`timescale 1ns / 100ps

module periodic_second_timer_scheduler_tb;

  localparam int NUM_SLOTS     = 8;
  localparam int TICKS_PER_SEC = 4096;

  typedef struct packed {
    logic        fired;
    logic [2:0]  slot;
    logic [31:0] seconds;
    logic        last;
  } report_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [psts_pkg::DATA_W-1:0]     s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [psts_pkg::DATA_W-1:0]     m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_we = 1'b0;
  logic [psts_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [psts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // timer scheduler shadow state
  logic [15:0] wake_cfg;
  logic [31:0] min_cfg;
  logic [31:0] max_cfg;
  logic [31:0] sec_count;
  logic [16:0] frac_count;
  logic        slot_armed [NUM_SLOTS];
  logic        slot_fires [NUM_SLOTS];
  logic [31:0] slot_period [NUM_SLOTS];
  logic [31:0] slot_due [NUM_SLOTS];

  report_t fire_reports[$];
  int      mismatch_count = 0;
  int      src_idle = 0;
  int      snk_idle = 0;

  periodic_second_timer_scheduler #(
    .SLOTS(NUM_SLOTS),
    .TICKS_PER_SECOND(TICKS_PER_SEC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= snk_idle);
  end

  task automatic push_report(input logic fired, input logic [2:0] slot, input logic last);
    report_t r;
    r.fired   = fired;
    r.slot    = slot;
    r.seconds = sec_count;
    r.last    = last;
    fire_reports.push_back(r);
  endtask

  task automatic predict_fires(input logic mode, input logic [2:0] slot,
                               input logic [31:0] period, input logic action);
    logic [31:0] p;
    int          i;
    if (mode == psts_pkg::MODE_START) begin
      p = period;
      if (p > max_cfg) p = max_cfg;
      if (p < min_cfg) p = min_cfg;
      slot_period[slot] = p;
      slot_fires[slot]  = action;
      slot_due[slot]    = sec_count + ((p > max_cfg) ? max_cfg : p);
      slot_armed[slot]  = 1'b1;
    end else begin
      frac_count = frac_count + wake_cfg;
      if (frac_count >= TICKS_PER_SEC) begin
        sec_count  = sec_count + 32'(frac_count / TICKS_PER_SEC);
        frac_count = '0;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_armed[i] && slot_due[i] <= sec_count) begin
            slot_due[i] = sec_count +
                          ((slot_period[i] > max_cfg) ? max_cfg : slot_period[i]);
            if (slot_fires[i]) push_report(1'b1, 3'(i), 1'b0);
          end
        end
      end
    end
    push_report(1'b0, 3'd0, 1'b1);
  endtask

  // entered and left at a falling edge
  task automatic send_request(input logic mode, input logic [2:0] slot,
                              input logic [31:0] period, input logic action);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {4'b0, action, period, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_fires(mode, slot, period, action);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (fire_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [psts_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [31:0] data);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      psts_pkg::REG_WAKE_INTERVAL: wake_cfg = data[15:0];
      psts_pkg::REG_MIN_PERIOD:    min_cfg  = data;
      psts_pkg::REG_MAX_PERIOD:    max_cfg  = data;
      default: ;
    endcase
  endtask

  task automatic test_default_config();
    send_request(psts_pkg::MODE_START, 3'd0, 32'd0, 1'b1);
    send_request(psts_pkg::MODE_START, 3'd1, 32'hFFFF_FFFF, 1'b0);
    send_request(psts_pkg::MODE_START, 3'd2, 32'd3, 1'b1);
    repeat (3) send_request(psts_pkg::MODE_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1);
    // restart of a running slot
    send_request(psts_pkg::MODE_START, 3'd2, 32'd2, 1'b0);
    repeat (2) send_request(psts_pkg::MODE_TICK, 3'd0, 32'd0, 1'b0);
    send_request(psts_pkg::MODE_START, 3'd6, 32'h8000_0001, 1'b1);
  endtask

  task automatic test_extreme_config();
    write_register(psts_pkg::REG_WAKE_INTERVAL, 32'd65535);
    write_register(psts_pkg::REG_MIN_PERIOD, 32'd0);
    write_register(psts_pkg::REG_MAX_PERIOD, 32'hFFFF_FFFF);
    // due time wraps past zero
    send_request(psts_pkg::MODE_START, 3'd3, 32'hFFFF_FFFF, 1'b1);
    send_request(psts_pkg::MODE_START, 3'd4, 32'd0, 1'b1);
    send_request(psts_pkg::MODE_START, 3'd7, 32'h5555_AAAA, 1'b1);
    repeat (2) send_request(psts_pkg::MODE_TICK, 3'd5, 32'hAAAA_5555, 1'b1);
    write_register(psts_pkg::REG_WAKE_INTERVAL, 32'd0);
    send_request(psts_pkg::MODE_TICK, 3'd0, 32'd0, 1'b0);
    write_register(psts_pkg::REG_WAKE_INTERVAL, 32'd1);
    send_request(psts_pkg::MODE_TICK, 3'd0, 32'd0, 1'b0);
  endtask

  task automatic test_min_above_max();
    write_register(psts_pkg::REG_WAKE_INTERVAL, 32'd65535);
    write_register(psts_pkg::REG_MIN_PERIOD, 32'd100);
    write_register(psts_pkg::REG_MAX_PERIOD, 32'd50);
    send_request(psts_pkg::MODE_START, 3'd5, 32'd7, 1'b1);
    repeat (4) send_request(psts_pkg::MODE_TICK, 3'd0, 32'd0, 1'b0);
    // reschedule picks up the new cap
    write_register(psts_pkg::REG_MAX_PERIOD, 32'd3);
    repeat (2) send_request(psts_pkg::MODE_TICK, 3'd0, 32'd0, 1'b0);
  endtask

  task automatic test_random(input int items, input int src, input int snk);
    int          k;
    logic [31:0] period;
    logic [31:0] val;
    src_idle = src;
    snk_idle = snk;
    for (k = 0; k < items; k++) begin
      if (k % 12 == 0) begin
        case ($urandom_range(3))
          0: val = 32'd65535;
          1: val = 32'd4096;
          2: val = $urandom_range(65535, 1);
          default: val = $urandom_range(8191, 2048);
        endcase
        write_register(psts_pkg::REG_WAKE_INTERVAL, val);
        case ($urandom_range(4))
          0: val = 32'd0;
          1: val = $urandom_range(5);
          2: val = 32'hFFFF_FFFF;
          default: val = $urandom_range(20);
        endcase
        write_register(psts_pkg::REG_MIN_PERIOD, val);
        case ($urandom_range(4))
          0: val = 32'hFFFF_FFFF;
          1: val = $urandom_range(40, 1);
          2: val = 32'd0;
          default: val = $urandom_range(100);
        endcase
        write_register(psts_pkg::REG_MAX_PERIOD, val);
      end
      case ($urandom_range(9))
        0: period = $urandom;
        1: period = 32'hFFFF_FFFF;
        2: period = 32'd0;
        default: period = $urandom_range(30);
      endcase
      if ($urandom_range(99) < 55)
        send_request(psts_pkg::MODE_TICK, 3'($urandom), $urandom, 1'($urandom));
      else
        send_request(psts_pkg::MODE_START, 3'($urandom), period, 1'($urandom));
    end
  endtask

  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (fire_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: fired %0d slot %0d seconds %0d last %0d",
                   m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tlast);
      end else begin
        want = fire_reports.pop_front();
        if (m_axis_tuser !== want.fired || m_axis_tdata[2:0] !== want.slot ||
            m_axis_tdata[34:3] !== want.seconds || m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("mismatch: exp fired %0d slot %0d seconds %0d last %0d, ",
                   want.fired, want.slot, want.seconds, want.last);
            $display("got fired %0d slot %0d seconds %0d last %0d",
                     m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    int i;
    wake_cfg   = psts_pkg::WAKE_RST;
    min_cfg    = psts_pkg::MIN_RST;
    max_cfg    = psts_pkg::MAX_RST;
    sec_count  = '0;
    frac_count = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_armed[i]  = 1'b0;
      slot_fires[i]  = 1'b0;
      slot_period[i] = '0;
      slot_due[i]    = '0;
    end
    src_idle = 22;
    snk_idle = 51;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_default_config();
    test_extreme_config();
    test_min_above_max();
    test_random(26, 22, 51);
    test_random(26, 51, 22);
    test_random(26, 0, 0);
    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && fire_reports.size() == 0) begin
      $display("periodic_second_timer_scheduler test passed");
    end else begin
      $display("periodic_second_timer_scheduler test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("periodic_second_timer_scheduler test failed");
    $finish;
  end

endmodule
